// ===== hw/rtl/blas_pkg.sv =====
package blas_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_REF  = 1'b1;

  localparam logic [1:0] CFG_MATCH    = 2'd0;
  localparam logic [1:0] CFG_MISMATCH = 2'd1;
  localparam logic [1:0] CFG_GAP      = 2'd2;

  localparam logic [6:0] MATCH_RST    = 7'd2;
  localparam logic [7:0] MISMATCH_RST = 8'hFF;
  localparam logic [7:0] GAP_RST      = 8'hFE;

  localparam logic [7:0] BASE_C = 8'h43;
  localparam logic [7:0] BASE_T = 8'h54;

  localparam int BEST_W = 20;
  localparam int REFE_W = 17;
  localparam int READE_W = 9;

  // control bits that travel with one reference row down the chain
  typedef struct packed {
    logic valid;
    logic first;    // first row of a run: previous row reads as zero
    logic score;    // row is within the reference length limit
    logic last;
    logic ovf;      // length overflow seen at the front
    logic sat;      // a cell of this row saturated
    logic best_ok;  // row best below holds a cell
  } ctl_t;

endpackage

// ===== hw/rtl/blas_front.sv =====
module blas_front #(
  parameter int MAX_READ_LEN = 256,
  parameter int MAX_REF_LEN  = 65536,
  parameter int LW = $clog2(MAX_READ_LEN + 1),
  parameter int IW = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1,
  parameter int CW = $clog2(MAX_REF_LEN + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              command,
  input  logic [7:0]        base,
  input  logic              last,
  output logic              run_done,
  output logic [LW-1:0]     rd_len,
  output logic              ld_en,
  output logic [IW-1:0]     ld_idx,
  output logic [7:0]        ld_base,
  output blas_pkg::ctl_t    tok_ctl,
  output logic [7:0]        tok_base,
  output logic [CW-1:0]     tok_row
);
  import blas_pkg::*;

  logic [CW-1:0] ref_cnt;
  logic          ovf;

  logic [CW-1:0] cnt_e, ref_cnt_next;
  logic [LW-1:0] len_e, rd_len_next;
  logic          ovf_e, ovf_next, run_done_next;
  logic          ld_en_next;
  ctl_t          ctl_next;

  always_comb begin
    cnt_e = run_done ? '0 : ref_cnt;
    ovf_e = run_done ? 1'b0 : ovf;
    len_e = (run_done && command == CMD_LOAD) ? '0 : rd_len;
    ref_cnt_next = ref_cnt;
    rd_len_next = rd_len;
    ovf_next = ovf;
    run_done_next = run_done;
    ld_en_next = 1'b0;
    ctl_next = '0;
    if (fire) begin
      ref_cnt_next = cnt_e;
      ovf_next = ovf_e;
      run_done_next = 1'b0;
      if (command == CMD_LOAD) begin
        rd_len_next = len_e;
        if (cnt_e == '0) begin
          if (len_e < LW'(MAX_READ_LEN)) begin
            ld_en_next = 1'b1;
            rd_len_next = len_e + LW'(1);
          end else begin
            ovf_next = 1'b1;
          end
        end
      end else begin
        ctl_next.valid = 1'b1;
        ctl_next.first = (cnt_e == '0);
        ctl_next.last = last;
        if (cnt_e < CW'(MAX_REF_LEN)) begin
          ctl_next.score = 1'b1;
          ref_cnt_next = cnt_e + CW'(1);
        end else begin
          ovf_next = 1'b1;
        end
        ctl_next.ovf = ovf_next;
        run_done_next = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_done <= 1'b1;
      rd_len <= '0;
      ref_cnt <= '0;
      ovf <= 1'b0;
      ld_en <= 1'b0;
      tok_ctl <= '0;
    end else begin
      run_done <= run_done_next;
      rd_len <= rd_len_next;
      ref_cnt <= ref_cnt_next;
      ovf <= ovf_next;
      ld_en <= ld_en_next;
      tok_ctl <= ctl_next;
    end
    ld_idx <= len_e[IW-1:0];
    ld_base <= base;
    tok_base <= base;
    tok_row <= ref_cnt_next;
  end

endmodule

// ===== hw/rtl/blas_cell.sv =====
module blas_cell #(
  parameter int J  = 0,
  parameter int SW = 20,
  parameter int LW = 9,
  parameter int IW = 8,
  parameter int CW = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [6:0]        match_score,
  input  logic signed [7:0] mismatch_score,
  input  logic signed [7:0] gap_score,
  input  logic [LW-1:0]     rd_len,
  input  logic              ld_en,
  input  logic [IW-1:0]     ld_idx,
  input  logic [7:0]        ld_base,
  input  blas_pkg::ctl_t    i_ctl,
  input  logic [7:0]        i_base,
  input  logic [CW-1:0]     i_row,
  input  logic [SW-1:0]     i_left,
  input  logic [SW-1:0]     i_diag,
  input  logic [SW-1:0]     i_bval,
  input  logic [LW-1:0]     i_bcol,
  output blas_pkg::ctl_t    o_ctl,
  output logic [7:0]        o_base,
  output logic [CW-1:0]     o_row,
  output logic [SW-1:0]     o_left,
  output logic [SW-1:0]     o_diag,
  output logic [SW-1:0]     o_bval,
  output logic [LW-1:0]     o_bcol
);
  import blas_pkg::*;

  localparam int AW = SW + 2;

  logic [7:0]    rd;
  logic [SW-1:0] up;

  logic                 active, work, hit, sat, take;
  logic [SW-1:0]        up_e, cval;
  logic signed [AW-1:0] add, c_diag, c_up, c_left, m, top;
  ctl_t                 ctl_next;

  always_comb begin
    active = LW'(J) < rd_len;
    work = i_ctl.valid && i_ctl.score && active;
    up_e = i_ctl.first ? '0 : up;
    hit = (i_base == rd) || (i_base == BASE_C && rd == BASE_T);
    add = hit ? AW'($signed({1'b0, match_score})) : AW'(mismatch_score);
    top = $signed({2'b00, {SW{1'b1}}});
    c_diag = $signed({2'b00, i_diag}) + add;
    c_up = $signed({2'b00, up_e}) + AW'(gap_score);
    c_left = $signed({2'b00, i_left}) + AW'(gap_score);
    m = c_diag;
    if (c_up > m) m = c_up;
    if (c_left > m) m = c_left;
    if (m < 0) m = '0;
    sat = 1'b0;
    if (m > top) begin
      m = top;
      sat = 1'b1;
    end
    cval = m[SW-1:0];
    take = work && (!i_ctl.best_ok || cval > i_bval);
    ctl_next = i_ctl;
    ctl_next.sat = i_ctl.sat | (work & sat);
    ctl_next.best_ok = i_ctl.best_ok | work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_ctl <= '0;
    end else begin
      o_ctl <= ctl_next;
    end
    if (ld_en && ld_idx == IW'(J)) begin
      rd <= ld_base;
    end
    if (work) begin
      up <= cval;
    end
    o_base <= i_base;
    o_row <= i_row;
    o_left <= cval;
    o_diag <= up_e;
    o_bval <= take ? cval : i_bval;
    o_bcol <= take ? LW'(J + 1) : i_bcol;
  end

endmodule

// ===== hw/rtl/blas_collect.sv =====
module blas_collect #(
  parameter int SW = 20,
  parameter int LW = 9,
  parameter int CW = 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  blas_pkg::ctl_t               i_ctl,
  input  logic [CW-1:0]                i_row,
  input  logic [SW-1:0]                i_bval,
  input  logic [LW-1:0]                i_bcol,
  input  logic                         res_ready,
  output logic                         res_valid,
  output logic [blas_pkg::BEST_W-1:0]  best_score,
  output logic [blas_pkg::REFE_W-1:0]  reference_end,
  output logic [blas_pkg::READE_W-1:0] read_end,
  output logic                         overflow
);
  import blas_pkg::*;

  logic          best_ok, sat_st;
  logic [SW-1:0] best;
  logic [CW-1:0] best_row;
  logic [LW-1:0] best_col;

  logic          ok_e, take, ok_next, sat_next;
  logic [SW-1:0] best_next;
  logic [CW-1:0] row_next;
  logic [LW-1:0] col_next;
  logic [63:0]   sc_x, row_x, col_x;

  always_comb begin
    ok_e = i_ctl.first ? 1'b0 : best_ok;
    best_next = i_ctl.first ? '0 : best;
    row_next = i_ctl.first ? '0 : best_row;
    col_next = i_ctl.first ? '0 : best_col;
    take = i_ctl.best_ok && (!ok_e || i_bval > best_next);
    if (take) begin
      best_next = i_bval;
      row_next = i_row;
      col_next = i_bcol;
    end
    ok_next = ok_e | take;
    sat_next = (i_ctl.first ? 1'b0 : sat_st) | i_ctl.sat;
    sc_x = ok_next ? 64'(best_next) : '0;
    row_x = ok_next ? 64'(row_next) : '0;
    col_x = ok_next ? 64'(col_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_ok <= 1'b0;
      sat_st <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (i_ctl.valid) begin
        best_ok <= ok_next;
        sat_st <= sat_next;
        if (i_ctl.last) begin
          res_valid <= 1'b1;
        end
      end
    end
    if (i_ctl.valid) begin
      best <= best_next;
      best_row <= row_next;
      best_col <= col_next;
      if (i_ctl.last) begin
        best_score <= sc_x[BEST_W-1:0];
        reference_end <= row_x[REFE_W-1:0];
        read_end <= col_x[READE_W-1:0];
        overflow <= sat_next | i_ctl.ovf;
      end
    end
  end

endmodule

// ===== hw/rtl/bisulfite_local_alignment_scorer.sv =====
// A result is formed as the last reference row passes the front register, each cell and the collector.
// Throughput: one reference base per cycle; a row walks a chain of one cell per read base.
// After a result the input holds off until the chain drains and the result is taken.
// Reset (rst, synchronous): scores 2 / -1 / -2, read empty, run done, no result pending.
module bisulfite_local_alignment_scorer #(
  parameter int MAX_READ_LEN = 256,
  parameter int MAX_REF_LEN  = 65536,
  parameter int SCORE_BITS   = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // base
  input  logic        s_tuser,   // command
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // best_score, reference_end, read_end, zero pad
  output logic        m_tuser,   // overflow
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import blas_pkg::*;

  localparam int N  = MAX_READ_LEN;
  localparam int SW = SCORE_BITS;
  localparam int LW = $clog2(MAX_READ_LEN + 1);
  localparam int IW = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1;
  localparam int CW = $clog2(MAX_REF_LEN + 1);
  localparam int NW = $clog2(MAX_READ_LEN + 2);

  logic [6:0]        match_score;
  logic signed [7:0] mismatch_score;
  logic signed [7:0] gap_score;

  logic          fire, run_done, busy, ld_en, tok_in, tok_out;
  logic [LW-1:0] rd_len;
  logic [IW-1:0] ld_idx;
  logic [7:0]    ld_base;
  logic [NW-1:0] inflight;

  ctl_t          c_ctl  [0:N];
  logic [7:0]    c_base [0:N];
  logic [CW-1:0] c_row  [0:N];
  logic [SW-1:0] c_left [0:N];
  logic [SW-1:0] c_diag [0:N];
  logic [SW-1:0] c_bval [0:N];
  logic [LW-1:0] c_bcol [0:N];

  logic [BEST_W-1:0]  best_score;
  logic [REFE_W-1:0]  reference_end;
  logic [READE_W-1:0] read_end;

  assign busy = (inflight != '0) || m_tvalid;
  assign s_tready = !(run_done && busy);
  assign fire = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign tok_in = fire && s_tuser == CMD_REF;
  assign tok_out = c_ctl[N].valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_score <= MATCH_RST;
      mismatch_score <= MISMATCH_RST;
      gap_score <= GAP_RST;
      inflight <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MATCH:    match_score <= cfg_data[6:0];
          CFG_MISMATCH: mismatch_score <= cfg_data;
          CFG_GAP:      gap_score <= cfg_data;
          default: ;
        endcase
      end
      inflight <= inflight + NW'(tok_in) - NW'(tok_out);
    end
  end

  blas_front #(
    .MAX_READ_LEN(MAX_READ_LEN),
    .MAX_REF_LEN (MAX_REF_LEN),
    .LW          (LW),
    .IW          (IW),
    .CW          (CW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .command (s_tuser),
    .base    (s_tdata),
    .last    (s_tlast),
    .run_done(run_done),
    .rd_len  (rd_len),
    .ld_en   (ld_en),
    .ld_idx  (ld_idx),
    .ld_base (ld_base),
    .tok_ctl (c_ctl[0]),
    .tok_base(c_base[0]),
    .tok_row (c_row[0])
  );

  assign c_left[0] = '0;
  assign c_diag[0] = '0;
  assign c_bval[0] = '0;
  assign c_bcol[0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_cell
    blas_cell #(
      .J (j),
      .SW(SW),
      .LW(LW),
      .IW(IW),
      .CW(CW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .match_score   (match_score),
      .mismatch_score(mismatch_score),
      .gap_score     (gap_score),
      .rd_len        (rd_len),
      .ld_en         (ld_en),
      .ld_idx        (ld_idx),
      .ld_base       (ld_base),
      .i_ctl         (c_ctl[j]),
      .i_base        (c_base[j]),
      .i_row         (c_row[j]),
      .i_left        (c_left[j]),
      .i_diag        (c_diag[j]),
      .i_bval        (c_bval[j]),
      .i_bcol        (c_bcol[j]),
      .o_ctl         (c_ctl[j+1]),
      .o_base        (c_base[j+1]),
      .o_row         (c_row[j+1]),
      .o_left        (c_left[j+1]),
      .o_diag        (c_diag[j+1]),
      .o_bval        (c_bval[j+1]),
      .o_bcol        (c_bcol[j+1])
    );
  end

  blas_collect #(
    .SW(SW),
    .LW(LW),
    .CW(CW)
  ) u_collect (
    .clk          (clk),
    .rst          (rst),
    .i_ctl        (c_ctl[N]),
    .i_row        (c_row[N]),
    .i_bval       (c_bval[N]),
    .i_bcol       (c_bcol[N]),
    .res_ready    (m_tready),
    .res_valid    (m_tvalid),
    .best_score   (best_score),
    .reference_end(reference_end),
    .read_end     (read_end),
    .overflow     (m_tuser)
  );

  assign m_tdata = {2'b00, read_end, reference_end, best_score};

  // a pending result blocks new requests
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input accepted while a result is pending");

  // the result leaves the chain empty
  a_drained: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> inflight == '0)
    else $error("rows still in flight behind a result");

  a_count: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_REF) |=> inflight != '0)
    else $error("reference row not counted");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import blas_pkg::*;

  localparam int READ_CAP = 256;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [7:0] BASE_A = 8'h41;
  localparam logic [7:0] BASE_G = 8'h47;

  typedef struct packed {
    logic       cmd;
    logic [7:0] base;
    logic       last;
  } base_req_t;

  typedef struct packed {
    logic [BEST_W-1:0]  score;
    logic [REFE_W-1:0]  ref_end;
    logic [READE_W-1:0] read_end;
    logic               ovf;
  } alignment_t;

  typedef enum logic [1:0] {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  bisulfite_local_alignment_scorer dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  base_req_t  pending_bases[$];
  alignment_t expected_alignments[$];
  base_req_t  next_req;
  alignment_t fresh_alignment;
  alignment_t want_alignment;
  alignment_t seen_alignment;
  int         queued_bases = 0;
  int         accepted_bases = 0;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  logic       s_took = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  bit         sender_gappy = 1'b1;
  sink_mode_t sink_mode = SINK_RANDOM;
  logic [15:0] sink_mask = 16'hA5C3;
  logic [3:0] sink_phase = '0;
  int         hold_asks = 0;
  int         hold_seen = 0;
  int         hold_left = 0;

  // alignment model state
  logic [6:0]        match_cfg;
  logic signed [7:0] mismatch_cfg;
  logic signed [7:0] gap_cfg;
  logic [7:0]        read_bases [READ_CAP];
  int                read_len;
  int                ref_rows;
  longint            row_cell [READ_CAP + 1];
  longint            best_cell;
  int                best_row;
  int                best_col;
  bit                best_seen;
  bit                run_closed;
  bit                ovf_seen;

  function automatic void clear_alignment();
    foreach (row_cell[j]) row_cell[j] = 0;
    ref_rows = 0;
    best_cell = 0;
    best_row = 0;
    best_col = 0;
    best_seen = 1'b0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void score_ref_base(input logic [7:0] b);
    longint diag;
    longint left;
    longint up;
    longint cur;
    longint top;
    bit     hit;
    top = (longint'(1) << BEST_W) - 1;
    diag = 0;
    left = 0;
    for (int j = 1; j <= read_len; j++) begin
      hit = (b == read_bases[j-1]) || (b == BASE_C && read_bases[j-1] == BASE_T);
      up = row_cell[j];
      cur = diag + (hit ? longint'(match_cfg) : longint'(mismatch_cfg));
      if (up + longint'(gap_cfg) > cur) cur = up + longint'(gap_cfg);
      if (left + longint'(gap_cfg) > cur) cur = left + longint'(gap_cfg);
      if (cur < 0) cur = 0;
      if (cur > top) begin
        cur = top;
        ovf_seen = 1'b1;
      end
      diag = up;
      row_cell[j] = cur;
      left = cur;
      if (!best_seen || cur > best_cell) begin
        best_seen = 1'b1;
        best_cell = cur;
        best_row = ref_rows;
        best_col = j;
      end
    end
  endfunction

  function automatic bit predict_alignment(input logic cmd, input logic [7:0] b,
                                           input logic lst, output alignment_t res);
    res = '0;
    if (cmd == CMD_LOAD) begin
      if (run_closed) begin
        read_len = 0;
        clear_alignment();
        run_closed = 1'b0;
      end
      if (ref_rows != 0) return 1'b0;
      if (read_len < READ_CAP) begin
        read_bases[read_len] = b;
        read_len++;
      end else begin
        ovf_seen = 1'b1;
      end
      return 1'b0;
    end
    if (run_closed) begin
      clear_alignment();
      run_closed = 1'b0;
    end
    ref_rows++;
    score_ref_base(b);
    if (!lst) return 1'b0;
    res.score = best_cell[BEST_W-1:0];
    res.ref_end = REFE_W'(best_row);
    res.read_end = READE_W'(best_col);
    res.ovf = ovf_seen;
    run_closed = 1'b1;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_base(input logic cmd, input logic [7:0] b, input logic lst);
    pending_bases.push_back('{cmd, b, lst});
    queued_bases++;
  endtask

  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 9))
      0, 1: return BASE_A;
      2, 3: return BASE_C;
      4, 5: return BASE_G;
      6, 7: return BASE_T;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly new read then reference; some runs reuse the stored read,
  // some slip read bases into the reference stream
  task automatic queue_random_runs(input int target);
    int made;
    int kind;
    int rlen;
    int flen;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        rlen = ($urandom_range(0, 39) == 0) ? $urandom_range(200, READ_CAP)
                                            : $urandom_range(1, 12);
        for (int k = 0; k < rlen; k++)
          queue_base(CMD_LOAD, pick_base(), 1'($urandom_range(0, 1)));
        made += rlen;
      end
      flen = $urandom_range(1, 16);
      for (int k = 0; k < flen; k++) begin
        if (kind >= 90 && $urandom_range(0, 3) == 0)
          queue_base(CMD_LOAD, pick_base(), 1'($urandom_range(0, 1)));
        queue_base(CMD_REF, pick_base(), k == flen - 1);
      end
      made += flen;
    end
  endtask

  task automatic write_setting(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (accepted_bases != queued_bases || expected_alignments.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_bases.size() > 0) begin
        next_req = pending_bases.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= next_req.cmd;
        s_tdata <= next_req.base;
        s_tlast <= next_req.last;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= (sender_gappy && $urandom_range(0, 1) == 1) ? $urandom_range(1, 12) : 0;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      sink_phase <= sink_phase + 4'd1;
      case (sink_mode)
        SINK_ALWAYS: m_tready <= 1'b1;
        SINK_RANDOM: m_tready <= $urandom_range(0, 3) != 0;
        default: m_tready <= sink_mask[sink_phase];
      endcase
    end
  end

  always @(posedge clk) begin
    s_took <= !rst && s_tvalid && s_tready;
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MATCH: match_cfg = cfg_data[6:0];
        CFG_MISMATCH: mismatch_cfg = cfg_data;
        CFG_GAP: gap_cfg = cfg_data;
        default: ;
      endcase
    end
    if (!rst && m_tvalid && m_tready) begin
      seen_alignment = {m_tdata[19:0], m_tdata[36:20], m_tdata[45:37], m_tuser};
      if (expected_alignments.size() == 0) begin
        report_mismatch("result with none pending", seen_alignment.score, 0);
      end else begin
        want_alignment = expected_alignments.pop_front();
        if (seen_alignment.score != want_alignment.score)
          report_mismatch("best_score", seen_alignment.score, want_alignment.score);
        if (seen_alignment.ref_end != want_alignment.ref_end)
          report_mismatch("reference_end", seen_alignment.ref_end, want_alignment.ref_end);
        if (seen_alignment.read_end != want_alignment.read_end)
          report_mismatch("read_end", seen_alignment.read_end, want_alignment.read_end);
        if (seen_alignment.ovf != want_alignment.ovf)
          report_mismatch("overflow", seen_alignment.ovf, want_alignment.ovf);
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      accepted_bases <= accepted_bases + 1;
      if (predict_alignment(s_tuser, s_tdata, s_tlast, fresh_alignment))
        expected_alignments.push_back(fresh_alignment);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bisulfite_local_alignment_scorer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int match_set [7];
    int mis_set [7];
    int gap_set [7];
    match_set = '{127, 0, 0, 127, 0, 0, 2};
    mis_set = '{-128, 127, -128, 127, 0, 0, -1};
    gap_set = '{-128, 127, -128, -1, 0, 0, -2};
    for (int p = 4; p < 6; p++) begin
      match_set[p] = $urandom_range(0, 127);
      mis_set[p] = $urandom_range(0, 255) - 128;
      gap_set[p] = $urandom_range(0, 255) - 128;
    end

    match_cfg = MATCH_RST;
    mismatch_cfg = MISMATCH_RST;
    gap_cfg = GAP_RST;
    read_len = 0;
    clear_alignment();
    run_closed = 1'b1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty read, C/T rule both ways, last on read, read during run, restart
    queue_base(CMD_REF, BASE_A, 1'b1);
    queue_base(CMD_LOAD, BASE_T, 1'b1);
    queue_base(CMD_LOAD, BASE_G, 1'b0);
    queue_base(CMD_LOAD, 8'h00, 1'b0);
    queue_base(CMD_LOAD, 8'hFF, 1'b0);
    queue_base(CMD_REF, BASE_C, 1'b0);
    queue_base(CMD_LOAD, BASE_A, 1'b0);
    queue_base(CMD_REF, 8'hFF, 1'b0);
    queue_base(CMD_REF, BASE_G, 1'b1);
    queue_base(CMD_REF, 8'h00, 1'b1);
    queue_base(CMD_LOAD, BASE_C, 1'b1);
    queue_base(CMD_LOAD, BASE_T, 1'b0);
    queue_base(CMD_REF, BASE_T, 1'b0);
    queue_base(CMD_REF, BASE_C, 1'b1);
    settle();

    // read longer than the store
    for (int k = 0; k < READ_CAP + 2; k++) queue_base(CMD_LOAD, pick_base(), 1'b0);
    for (int k = 0; k < 3; k++) queue_base(CMD_REF, pick_base(), k == 2);
    settle();

    for (int p = 0; p < 7; p++) begin
      write_setting(CFG_MATCH, {1'($urandom_range(0, 1)), 7'(match_set[p])});
      write_setting(CFG_MISMATCH, 8'(mis_set[p]));
      write_setting(CFG_GAP, 8'(gap_set[p]));
      sender_gappy = (p % 2) == 0;
      sink_mode = sink_mode_t'(p % 3);
      sink_mask = 16'($urandom_range(1, 65535));
      if (p == 3) begin
        sender_gappy = 1'b0;
        sink_mode = SINK_ALWAYS;
      end
      queue_random_runs(160);
      if (p == 3) begin
        @(posedge clk);
        hold_asks++;
      end
      settle();
    end

    if (mismatch_count == 0 && expected_alignments.size() == 0) begin
      $display("bisulfite_local_alignment_scorer verification clean");
    end else begin
      $display("bisulfite_local_alignment_scorer verification failed");
    end
    $finish;
  end

endmodule
